[hdl/pbra_pkg.sv]
// Shared types and constants of the page bitmap run allocator.
// Used by the top level; no dependencies.
`default_nettype none

package pbra_pkg;

   // Store size in pages
   localparam int PAGE_TOTAL = 4096;

   // Usage map word geometry
   localparam int WORD_W   = 32;
   localparam int WORD_LSB = 5;
   localparam int TZ_W     = 6;   // free streak inside one word, 0..32

   // Transaction field widths
   localparam int LEN_W   = 13;
   localparam int IDX_W   = 12;
   localparam int START_W = 12;
   localparam int USED_W  = 13;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FAIL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage

`default_nettype wire

[hdl/page_bitmap_run_allocator.sv]
// First-fit allocator of contiguous page runs over a usage bitmap held in pbra_ram.
// A rejected request goes straight to S_DONE; an allocate scans map words up to the
// hit, then rewrites the words the run spans; a free rewrites just the words the run spans.
// One map word is read per cycle. One transaction at a time; the next is accepted while
// a result waits on rsp_stall. Reset: synchronous; a fill pass over PAGE_TOTAL/32 map words
// (128) marks every page used, with req_stall high.
`default_nettype none

module page_bitmap_run_allocator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_mode,
   input  wire logic [pbra_pkg::LEN_W-1:0]   req_run_length,
   input  wire logic [pbra_pkg::IDX_W-1:0]   req_page_index,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output pbra_pkg::status_type              rsp_status,
   output logic      [pbra_pkg::START_W-1:0] rsp_start_page,
   output logic      [pbra_pkg::USED_W-1:0]  rsp_used_pages
);

   import pbra_pkg::*;

   localparam int NUM_WORDS = (PAGE_TOTAL + WORD_W - 1) / WORD_W;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int POS_W     = ADDR_W + WORD_LSB;
   localparam int CNT_W     = $clog2(PAGE_TOTAL + 1);
   localparam int EXT_W     = ((POS_W > 14) ? POS_W : 14) + 2;

   localparam logic [ADDR_W-1:0] LAST_WORD      = ADDR_W'(NUM_WORDS - 1);
   localparam logic [EXT_W-1:0]  PAGE_TOTAL_EXT = EXT_W'(PAGE_TOTAL);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_PREP,
      S_MARK,
      S_DONE
   } state_type;

   // Control and pipeline registers
   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic                issue_done_ff, issue_done_in;
   logic                p1_v_ff, p1_v_in;
   logic [ADDR_W-1:0]   p1_addr_ff, p1_addr_in;
   logic                t_v_ff, t_v_in;
   logic [ADDR_W-1:0]   t_addr_ff, t_addr_in;
   logic [TZ_W-1:0]     t_tz_ff [WORD_W];
   logic [TZ_W-1:0]     t_tz_in [WORD_W];
   logic [WORD_W-1:0]   t_allf_ff, t_allf_in;
   logic [CNT_W-1:0]    streak_ff, streak_in;
   logic [POS_W-1:0]    run_first_ff, run_first_in;
   logic [POS_W-1:0]    run_last_ff, run_last_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   status_type          res_status_ff, res_status_in;
   logic [START_W-1:0]  res_start_ff, res_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   // RAM port signals
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [WORD_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [WORD_W-1:0]   ram_rdata;

   // Request decode
   logic                req_accept;
   logic [EXT_W-1:0]    len_ext, idx_ext, used_ext, req_end_ext;
   logic                alloc_ok, free_range_bad;

   // Scan datapath
   logic [TZ_W-1:0]     scan_tz [WORD_W];
   logic [WORD_W-1:0]   scan_allf;
   logic [WORD_W-1:0]   hit_vec;
   logic                hit_found;
   logic [WORD_LSB-1:0] hit_bit;
   logic [POS_W-1:0]    hit_end;
   logic [CNT_W-1:0]    streak_next;
   logic [EXT_W-1:0]    prep_first_ext;

   // Mark datapath
   logic [ADDR_W-1:0]   run_first_word, run_last_word;
   logic [WORD_W-1:0]   mark_mask;
   logic [WORD_W-1:0]   mark_word;
   logic [TZ_W-1:0]     freed_cnt;

   pbra_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   // Handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Request checks
   assign len_ext        = EXT_W'(req_run_length);
   assign idx_ext        = EXT_W'(req_page_index);
   assign used_ext       = EXT_W'(used_ff);
   assign req_end_ext    = idx_ext + len_ext - EXT_W'(1);
   assign alloc_ok       = (req_run_length != '0) && ((used_ext + len_ext) <= PAGE_TOTAL_EXT);
   assign free_range_bad = (idx_ext + len_ext) > PAGE_TOTAL_EXT;

   // Free streak ending at each bit of the word coming out of the RAM
   always_comb begin
      logic [TZ_W-1:0] last_used;
      for (int j = 0; j < WORD_W; j++) begin
         last_used = '0;
         for (int k = 0; k <= j; k++) begin
            if (ram_rdata[k]) begin
               last_used = TZ_W'(k + 1);
            end
         end
         scan_tz[j]   = TZ_W'(j + 1) - last_used;
         scan_allf[j] = (last_used == '0);
      end
   end

   // Run detection against the streak carried in from earlier words
   always_comb begin
      logic [EXT_W-1:0] run_len;
      for (int j = 0; j < WORD_W; j++) begin
         run_len = t_allf_ff[j] ? (EXT_W'(streak_ff) + EXT_W'(j + 1)) : EXT_W'(t_tz_ff[j]);
         hit_vec[j] = t_v_ff && (run_len >= EXT_W'(len_ff));
      end
      hit_found = 1'b0;
      hit_bit   = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_found = 1'b1;
            hit_bit   = WORD_LSB'(j);
         end
      end
   end

   assign hit_end        = {t_addr_ff, hit_bit};
   assign streak_next    = t_allf_ff[WORD_W-1] ? (streak_ff + CNT_W'(WORD_W))
                                              : CNT_W'(t_tz_ff[WORD_W-1]);
   assign prep_first_ext = EXT_W'(run_last_ff) + EXT_W'(1) - EXT_W'(len_ff);

   // Bit mask of the run within the word being rewritten
   assign run_first_word = run_first_ff[POS_W-1:WORD_LSB];
   assign run_last_word  = run_last_ff[POS_W-1:WORD_LSB];

   always_comb begin
      logic [WORD_LSB-1:0] lo;
      logic [WORD_LSB-1:0] hi;
      lo = (p1_addr_ff == run_first_word) ? run_first_ff[WORD_LSB-1:0] : '0;
      hi = (p1_addr_ff == run_last_word) ? run_last_ff[WORD_LSB-1:0] : '1;
      for (int b = 0; b < WORD_W; b++) begin
         mark_mask[b] = (WORD_LSB'(b) >= lo) && (WORD_LSB'(b) <= hi);
      end
   end

   assign mark_word = (mode_ff == MODE_FREE) ? (ram_rdata & ~mark_mask) : (ram_rdata | mark_mask);
   assign freed_cnt = TZ_W'($countones(ram_rdata & mark_mask));

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      rd_addr_in    = rd_addr_ff;
      issue_done_in = issue_done_ff;
      p1_v_in       = 1'b0;
      p1_addr_in    = p1_addr_ff;
      t_v_in        = 1'b0;
      t_addr_in     = t_addr_ff;
      t_tz_in       = t_tz_ff;
      t_allf_in     = t_allf_ff;
      streak_in     = streak_ff;
      run_first_in  = run_first_ff;
      run_last_in   = run_last_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_used_in   = rsp_used_ff;
      ram_we        = 1'b0;
      ram_waddr     = p1_addr_ff;
      ram_wdata     = mark_word;
      ram_re        = 1'b0;

      // Shared read issue for scan and mark passes
      if ((state_ff == S_SCAN || state_ff == S_MARK) && !issue_done_ff) begin
         ram_re     = 1'b1;
         p1_v_in    = 1'b1;
         p1_addr_in = rd_addr_ff;
         if (rd_addr_ff == ((state_ff == S_SCAN) ? LAST_WORD : run_last_word)) begin
            issue_done_in = 1'b1;
         end else begin
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_ff;
            ram_wdata = '1;
            if (rd_addr_ff == LAST_WORD) begin
               rd_addr_in = '0;
               state_in   = S_IDLE;
            end else begin
               rd_addr_in = rd_addr_ff + ADDR_W'(1);
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               mode_in       = mode_type'(req_mode);
               len_in        = req_run_length;
               issue_done_in = 1'b0;
               streak_in     = '0;
               res_start_in  = '0;
               if (mode_type'(req_mode) == MODE_ALLOC) begin
                  if (alloc_ok) begin
                     rd_addr_in = '0;
                     state_in   = S_SCAN;
                  end else begin
                     res_status_in = STATUS_FAIL;
                     state_in      = S_DONE;
                  end
               end else if (req_run_length == '0) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_DONE;
               end else if (free_range_bad) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = S_DONE;
               end else begin
                  run_first_in  = idx_ext[POS_W-1:0];
                  run_last_in   = req_end_ext[POS_W-1:0];
                  rd_addr_in    = idx_ext[POS_W-1:WORD_LSB];
                  res_status_in = STATUS_OK;
                  state_in      = S_MARK;
               end
            end
         end

         S_SCAN: begin
            t_v_in    = p1_v_ff;
            t_addr_in = p1_addr_ff;
            t_tz_in   = scan_tz;
            t_allf_in = scan_allf;
            if (t_v_ff) begin
               if (hit_found) begin
                  run_last_in = hit_end;
                  state_in    = S_PREP;
               end else if (t_addr_ff == LAST_WORD) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_DONE;
               end else begin
                  streak_in = streak_next;
               end
            end
         end

         S_PREP: begin
            run_first_in  = prep_first_ext[POS_W-1:0];
            rd_addr_in    = prep_first_ext[POS_W-1:WORD_LSB];
            issue_done_in = 1'b0;
            res_status_in = STATUS_OK;
            res_start_in  = prep_first_ext[START_W-1:0];
            used_in       = CNT_W'(used_ext + EXT_W'(len_ff));
            state_in      = S_MARK;
         end

         S_MARK: begin
            if (p1_v_ff) begin
               ram_we = 1'b1;
               if (mode_ff == MODE_FREE) begin
                  used_in = used_ff - CNT_W'(freed_cnt);
               end
               if (p1_addr_ff == run_last_word) begin
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_used_in   = used_ext[USED_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, pipeline and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rd_addr_ff    <= '0;
         issue_done_ff <= 1'b0;
         p1_v_ff       <= 1'b0;
         t_v_ff        <= 1'b0;
         used_ff       <= CNT_W'(PAGE_TOTAL);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_addr_ff    <= rd_addr_in;
         issue_done_ff <= issue_done_in;
         p1_v_ff       <= p1_v_in;
         t_v_ff        <= t_v_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      len_ff        <= len_in;
      p1_addr_ff    <= p1_addr_in;
      t_addr_ff     <= t_addr_in;
      t_tz_ff       <= t_tz_in;
      t_allf_ff     <= t_allf_in;
      streak_ff     <= streak_in;
      run_first_ff  <= run_first_in;
      run_last_ff   <= run_last_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_page = rsp_start_ff;
   assign rsp_used_pages = rsp_used_ff;

endmodule

`default_nettype wire

[hdl/pbra_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pbra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[bench/tb_page_bitmap_run_allocator.sv]
// Self-checking bench for page_bitmap_run_allocator: directed corner cases, then random
// allocate/free traffic with random gaps on both channels. Depends on pbra_pkg and the RTL.
`timescale 1ns / 1ps

module tb_page_bitmap_run_allocator;
   import pbra_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 300;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      status_type               status;
      logic [START_W-1:0]       start_page;
      logic [USED_W-1:0]        used_pages;
   } reply_type;

   // Tracks the page usage map and the replies still owed by the block
   class page_usage_board;
      bit          page_used [PAGE_TOTAL];
      int unsigned used_cnt;
      reply_type   awaited_replies [$];
      int unsigned errors;

      function new();
         foreach (page_used[i]) page_used[i] = 1'b1;
         used_cnt = PAGE_TOTAL;
         errors   = 0;
      endfunction

      // Lowest start of a free run of len pages, -1 when there is none
      function int first_fit(int len);
         int streak;
         int first;
         streak = 0;
         first  = 0;
         for (int i = 0; i < PAGE_TOTAL; i++) begin
            if (!page_used[i]) begin
               if (streak == 0) first = i;
               streak++;
               if (streak == len) return first;
            end else begin
               streak = 0;
            end
         end
         return -1;
      endfunction

      // Update the map for one accepted transaction and queue its reply
      function reply_type apply_request(mode_type mode, int len, int idx);
         reply_type rep;
         int        s;
         rep.status     = STATUS_FAIL;
         rep.start_page = '0;
         if (mode == MODE_ALLOC) begin
            if (len != 0 && used_cnt + len <= PAGE_TOTAL) begin
               s = first_fit(len);
               if (s >= 0) begin
                  for (int i = s; i < s + len; i++) page_used[i] = 1'b1;
                  used_cnt      += len;
                  rep.start_page = START_W'(s);
                  rep.status     = STATUS_OK;
               end
            end
         end else begin
            if (len == 0) begin
               rep.status = STATUS_FAIL;
            end else if (idx + len > PAGE_TOTAL) begin
               rep.status = STATUS_RANGE;
            end else begin
               for (int i = idx; i < idx + len; i++) begin
                  if (page_used[i]) begin
                     page_used[i] = 1'b0;
                     used_cnt--;
                  end
               end
               rep.status = STATUS_OK;
            end
         end
         rep.used_pages = USED_W'(used_cnt);
         awaited_replies.push_back(rep);
         return rep;
      endfunction

      // Compare one accepted reply with the oldest one owed
      function void check_reply(status_type status, logic [START_W-1:0] start_page,
                                logic [USED_W-1:0] used_pages);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected reply, status %0d start %0d used %0d",
                     $time, status, start_page, used_pages);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
         end
         if (start_page !== want.start_page) begin
            $display("%0t: start_page mismatch, expected %0d, actual %0d",
                     $time, want.start_page, start_page);
            errors++;
         end
         if (used_pages !== want.used_pages) begin
            $display("%0t: used_pages mismatch, expected %0d, actual %0d",
                     $time, want.used_pages, used_pages);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic [LEN_W-1:0]   req_run_length;
   logic [IDX_W-1:0]   req_page_index;
   logic               rsp_valid;
   logic               rsp_stall;
   status_type         rsp_status;
   logic [START_W-1:0] rsp_start_page;
   logic [USED_W-1:0]  rsp_used_pages;

   page_usage_board board;
   int unsigned     req_sent;
   int unsigned     rsp_seen;
   int unsigned     cycle_cnt;
   int              run_starts [$];
   int              run_lens [$];

   page_bitmap_run_allocator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_run_length (req_run_length),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_start_page (rsp_start_page),
      .rsp_used_pages (rsp_used_pages)
   );

   // Clock and the cycle limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_cnt = 0;
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_page_bitmap_run_allocator failed");
            $finish;
         end
      end
   end

   // Random gap before each transaction, with every fourth stretch of 50 transactions back to back
   function automatic int draw_gap(int unsigned seq);
      if ((seq / 50) % 4 == 3) return 0;
      return $urandom_range(0, 8);
   endfunction

   // Mostly short runs, a few large ones, rare zero or oversized lengths
   function automatic int pick_alloc_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 32);
      if (r < 90) return $urandom_range(33, 300);
      if (r < 97) return $urandom_range(301, 4096);
      if (r < 98) return 0;
      return $urandom_range(4097, 8191);
   endfunction

   // Drive one request transaction and note it once accepted
   task automatic send_request(input mode_type mode, input int len, input int idx);
      int        gap;
      reply_type rep;
      gap = draw_gap(req_sent);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode       = mode;
      req_run_length = LEN_W'(len);
      req_page_index = IDX_W'(idx);
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      rep = board.apply_request(mode, len, idx);
      req_sent++;
      if (mode == MODE_ALLOC && rep.status == STATUS_OK) begin
         run_starts.push_back(int'(rep.start_page));
         run_lens.push_back(len);
      end
   endtask

   task automatic alloc_pages(input int len);
      send_request(MODE_ALLOC, len, $urandom_range(0, PAGE_TOTAL - 1));
   endtask

   task automatic free_pages(input int idx, input int len);
      send_request(MODE_FREE, len, idx);
   endtask

   // Response side: random stall, then check each accepted reply
   initial begin
      int gap;
      rsp_stall = 1'b0;
      rsp_seen  = 0;
      @(negedge clock);
      forever begin
         gap = draw_gap(rsp_seen);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_reply(rsp_status, rsp_start_page, rsp_used_pages);
         rsp_seen++;
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin
      int r;
      int j;
      board          = new();
      req_sent       = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_ALLOC;
      req_run_length = '0;
      req_page_index = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: everything used after reset
      alloc_pages(1);                  // too large: count full
      alloc_pages(0);                  // zero-length allocate
      free_pages(5, 0);                // zero-length free
      free_pages(4095, 2);             // free past the store
      free_pages(4095, 1);             // last page, exactly at the end
      free_pages(0, 8191);             // widest length, out of range
      free_pages(0, 4096);             // free the whole store
      alloc_pages(4096);               // whole store in one run
      free_pages(0, 4096);
      alloc_pages(4097);               // larger than the store
      alloc_pages(8191);
      alloc_pages(1);
      alloc_pages(31);
      alloc_pages(2);                  // run starting at a word boundary
      free_pages(100, 10);             // already free pages
      free_pages(0, 40);               // mix of used and free pages
      free_pages(0, 4096);
      alloc_pages(2048);
      free_pages(1000, 1);
      alloc_pages(2049);               // count fits but no run found
      alloc_pages(2048);
      alloc_pages(1);                  // fills the single hole
      free_pages(0, 4096);
      run_starts.delete();
      run_lens.delete();

      // Random: well-formed allocate/free traffic with some noise
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            alloc_pages(pick_alloc_len());
         end else if (r < 80 && run_starts.size() > 0) begin
            j = $urandom_range(0, run_starts.size() - 1);
            free_pages(run_starts[j], run_lens[j]);
            run_starts.delete(j);
            run_lens.delete(j);
         end else if (r < 92) begin
            free_pages($urandom_range(0, PAGE_TOTAL - 1), $urandom_range(1, 64));
         end else if (r < 97) begin
            free_pages($urandom_range(0, PAGE_TOTAL - 1), $urandom_range(0, 8191));
         end else begin
            free_pages(0, PAGE_TOTAL);
            run_starts.delete();
            run_lens.delete();
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      // Drain, then allow stray replies to show up
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_page_bitmap_run_allocator passed");
      end else begin
         $display("tb_page_bitmap_run_allocator failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/pbra_pkg.sv
hdl/pbra_ram.sv
hdl/page_bitmap_run_allocator.sv
bench/tb_page_bitmap_run_allocator.sv
